// ===== rtl/core/utv_pkg.sv =====
// ----------------------------------------------------------------------------
// utv_pkg
// Shared constants and helpers for the UTC timestamp validator: template
// positions, ASCII codes, range limits and the decimal accumulate step.
// ----------------------------------------------------------------------------
package utv_pkg;

  localparam int unsigned PosW = 5;
  localparam int unsigned ValW = 7;

  localparam logic [PosW-1:0] POS_MAX     = 5'd31;
  localparam logic [PosW-1:0] STAMP_LEN   = 5'd20;
  localparam logic [PosW-1:0] POS_DASH_A  = 5'd4;
  localparam logic [PosW-1:0] POS_DASH_B  = 5'd7;
  localparam logic [PosW-1:0] POS_T       = 5'd10;
  localparam logic [PosW-1:0] POS_COLON_A = 5'd13;
  localparam logic [PosW-1:0] POS_COLON_B = 5'd16;
  localparam logic [PosW-1:0] POS_Z       = 5'd19;
  localparam logic [PosW-1:0] POS_YHI_END = 5'd1;
  localparam logic [PosW-1:0] POS_YLO_END = 5'd3;
  localparam logic [PosW-1:0] POS_MON_END = 5'd6;
  localparam logic [PosW-1:0] POS_DAY_END = 5'd9;
  localparam logic [PosW-1:0] POS_HR_END  = 5'd12;
  localparam logic [PosW-1:0] POS_MIN_END = 5'd15;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [ValW-1:0] MONTH_MAX  = 7'd12;
  localparam logic [ValW-1:0] HOUR_MAX   = 7'd23;
  localparam logic [ValW-1:0] MINSEC_MAX = 7'd59;
  localparam logic [ValW-1:0] FEB        = 7'd2;

  // One decimal digit shifted into a two-digit field: v * 10 + d.
  function automatic logic [ValW-1:0] acc_dec(logic [ValW-1:0] v, logic [3:0] d);
    logic [ValW+3:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{(ValW){1'b0}}, d};
    return t[ValW-1:0];
  endfunction

  // Days in the month; February grows to 29 days in a leap year.
  function automatic logic [ValW-1:0] month_days(logic [ValW-1:0] month, logic leap);
    logic [ValW-1:0] lim;
    unique case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: lim = 7'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    lim = 7'd30;
      FEB:                                        lim = leap ? 7'd29 : 7'd28;
      default:                                    lim = 7'd0;
    endcase
    return lim;
  endfunction

endpackage

// ===== rtl/core/utc_timestamp_validator.sv =====
// ----------------------------------------------------------------------------
// utc_timestamp_validator
// Checks a byte stream against the form YYYY-MM-DDTHH:MM:SSZ and reports
// whether the whole string is a valid UTC timestamp.
// ----------------------------------------------------------------------------
// The input channel carries one text byte per beat on char_in, with
// last_char set on the final byte of a string. The output channel carries
// one beat per string, stamp_valid, produced by the byte marked last_char.
// Bytes are taken one per cycle unless a result waits on out_ready; each
// byte does its template check and decimal accumulate in the cycle it is
// accepted, so the block sustains one byte per clock while not stalled. The
// result appears on the output register in the cycle after the last byte.
// The output is a single register. While it holds a result that the
// receiver has not taken, in_ready is low; as soon as out_ready is high the
// register can be refilled in the same cycle, so no bubble is lost.
// A synchronous reset empties the output register and returns the position
// counter and all fields to the start of a string. After every string the
// position counter and all fields are restored, ready for the next one.
// ----------------------------------------------------------------------------
module utc_timestamp_validator
  import utv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       stamp_valid
);

  logic [PosW-1:0] char_position;
  logic            format_good;
  logic [ValW-1:0] year_hi;
  logic [ValW-1:0] year_lo;
  logic [ValW-1:0] month;
  logic [ValW-1:0] day;
  logic [ValW-1:0] hour;
  logic [ValW-1:0] minute;
  logic [ValW-1:0] second;

  logic            format_good_next;
  logic [ValW-1:0] year_hi_next;
  logic [ValW-1:0] year_lo_next;
  logic [ValW-1:0] month_next;
  logic [ValW-1:0] day_next;
  logic [ValW-1:0] hour_next;
  logic [ValW-1:0] minute_next;
  logic [ValW-1:0] second_next;

  logic            in_fire;
  logic            is_digit;
  logic [3:0]      digit;
  logic            leap;
  logic            date_good;
  logic            stamp_ok;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_digit = (char_in >= CH_0) && (char_in <= CH_9);
  assign digit    = char_in[3:0];

  always_comb begin
    format_good_next = format_good;
    year_hi_next     = year_hi;
    year_lo_next     = year_lo;
    month_next       = month;
    day_next         = day;
    hour_next        = hour;
    minute_next      = minute;
    second_next      = second;
    if (char_position >= STAMP_LEN) begin
      format_good_next = 1'b0;
    end else begin
      unique case (char_position) inside
        POS_DASH_A, POS_DASH_B: begin
          if (char_in != CH_DASH) format_good_next = 1'b0;
        end
        POS_T: begin
          if (char_in != CH_T) format_good_next = 1'b0;
        end
        POS_COLON_A, POS_COLON_B: begin
          if (char_in != CH_COLON) format_good_next = 1'b0;
        end
        POS_Z: begin
          if (char_in != CH_Z) format_good_next = 1'b0;
        end
        default: begin
          if (!is_digit) begin
            format_good_next = 1'b0;
          end else if (char_position <= POS_YHI_END) begin
            year_hi_next = acc_dec(year_hi, digit);
          end else if (char_position <= POS_YLO_END) begin
            year_lo_next = acc_dec(year_lo, digit);
          end else if (char_position <= POS_MON_END) begin
            month_next = acc_dec(month, digit);
          end else if (char_position <= POS_DAY_END) begin
            day_next = acc_dec(day, digit);
          end else if (char_position <= POS_HR_END) begin
            hour_next = acc_dec(hour, digit);
          end else if (char_position <= POS_MIN_END) begin
            minute_next = acc_dec(minute, digit);
          end else begin
            second_next = acc_dec(second, digit);
          end
        end
      endcase
    end
  end

  // The year is held as two decimal halves, so the leap rule reduces to
  // low-bit tests: divisible by 4, and a century year only if its upper
  // half is divisible by 4 as well.
  assign leap = (year_lo[1:0] == 2'b00) &&
                ((year_lo != '0) || (year_hi[1:0] == 2'b00));

  assign date_good = ((year_hi != '0) || (year_lo != '0)) &&
                     (month != '0) && (month <= MONTH_MAX) &&
                     (day != '0) && (day <= month_days(month, leap));

  assign stamp_ok = format_good_next && (char_position == POS_Z) && date_good &&
                    (hour <= HOUR_MAX) && (minute <= MINSEC_MAX) &&
                    (second <= MINSEC_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      format_good   <= 1'b1;
      year_hi       <= '0;
      year_lo       <= '0;
      month         <= '0;
      day           <= '0;
      hour          <= '0;
      minute        <= '0;
      second        <= '0;
    end else if (in_fire) begin
      if (last_char) begin
        char_position <= '0;
        format_good   <= 1'b1;
        year_hi       <= '0;
        year_lo       <= '0;
        month         <= '0;
        day           <= '0;
        hour          <= '0;
        minute        <= '0;
        second        <= '0;
      end else begin
        if (char_position != POS_MAX) char_position <= char_position + 1'b1;
        format_good <= format_good_next;
        year_hi     <= year_hi_next;
        year_lo     <= year_lo_next;
        month       <= month_next;
        day         <= day_next;
        hour        <= hour_next;
        minute      <= minute_next;
        second      <= second_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_char) begin
      stamp_valid <= stamp_ok;
    end
  end

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_char && (char_position != POS_MAX)
    |=> char_position == $past(char_position) + 1'b1)
    else $error("position counter did not advance on a non-final beat");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_char |=> (char_position == '0) && format_good && out_valid)
    else $error("state not restored after the final beat");

  a_wrong_length: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_char && (char_position != POS_Z) |=> !stamp_valid)
    else $error("string of wrong length reported as valid");

  a_too_long: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_char && (char_position >= STAMP_LEN) |=> !format_good)
    else $error("overlong string not marked as bad format");

endmodule
